>>> hdl/plob_pkg.sv
// ----------------------------------------------------------------------------
// Price level order book package
// Shared sizes, codes, the stored slot record and small helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package plob_pkg;

  // Book and table geometry.
  localparam int NUM_PRICES  = 262144;
  localparam int TABLE_SLOTS = 131072;

  // Field widths of the items.
  localparam int ID_W     = 64;
  localparam int PRICE_W  = 18;
  localparam int QTY_W    = 31;
  localparam int STATUS_W = 2;
  localparam int LVL_W    = 48;

  // Derived address widths. A leaf word covers 64 prices, a middle word 64 leaves.
  localparam int SLOT_AW   = $clog2(TABLE_SLOTS);
  localparam int CNT_W     = SLOT_AW;
  localparam int HALF_LOAD = TABLE_SLOTS / 2;
  localparam int LEAF_IW   = PRICE_W - 6;
  localparam int MID_IW    = PRICE_W - 12;
  localparam int LVL_AW    = PRICE_W + 1;
  localparam int LEAF_AW   = LEAF_IW + 1;
  localparam int MID_AW    = MID_IW + 1;

  // The clearing pass covers the largest memory.
  localparam int CLR_N = ((2 ** LVL_AW) > TABLE_SLOTS) ? (2 ** LVL_AW) : TABLE_SLOTS;
  localparam int CLR_W = $clog2(CLR_N);

  // Hash finalizer multipliers.
  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

  // Item codes.
  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_CANCEL = 1'b1;
  localparam logic SIDE_BID    = 1'b0;
  localparam logic SIDE_ASK    = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  // One table slot apart from its id.
  typedef struct packed {
    logic               used;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } slot_info_t;

  // Clamp a price to the top of the book.
  function automatic logic [PRICE_W-1:0] sat_price(input logic [PRICE_W-1:0] p);
    logic [PRICE_W:0] ext;
    ext = {1'b0, p};
    if (ext >= (PRICE_W + 1)'(NUM_PRICES)) begin
      return PRICE_W'(NUM_PRICES - 1);
    end
    return p;
  endfunction

  // Index of the highest set bit; zero for an empty word.
  function automatic logic [5:0] hi_bit(input logic [63:0] w);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (w[i]) begin
        n = 6'(i);
      end
    end
    return n;
  endfunction

  // Index of the lowest set bit; 63 for an empty word.
  function automatic logic [5:0] lo_bit(input logic [63:0] w);
    logic [5:0] n;
    n = 6'd63;
    for (int i = 63; i >= 0; i--) begin
      if (w[i]) begin
        n = 6'(i);
      end
    end
    return n;
  endfunction

  // True when k lies in the ring interval (a, b].
  function automatic logic ring_between(input logic [SLOT_AW-1:0] a,
                                        input logic [SLOT_AW-1:0] k,
                                        input logic [SLOT_AW-1:0] b);
    if (a <= b) begin
      return (a < k) && (k <= b);
    end
    return (a < k) || (k <= b);
  endfunction

endpackage

`default_nettype wire

>>> hdl/price_level_order_book.sv
// ----------------------------------------------------------------------------
// Price level order book
// Order table with linear probing and backward-shift deletion, per-side
// level sums and three-level occupancy bitmaps giving best bid and best ask.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the level, slot and bitmap
// memories and holds in_tready low until it ends. Items are then taken one at
// a time. An item is hashed from the accept on, probes the table slot by slot,
// updates its level sum, updates the bitmaps where a level becomes occupied or
// empty, searches the best price of each side and then hands the result over.
// A cancel also frees its slot and walks on by backward-shift deletion, moving
// back each entry that may move, until a free slot ends the walk; every walked
// entry is rehashed on the single hash multiplier. A finished result waits in
// the output register while the next item is accepted; if that register is
// still full when the next result is ready, the block waits in hand-off with
// in_tready low until out_tready drains it.
// ----------------------------------------------------------------------------
`default_nettype none

module price_level_order_book (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // order_id[63:0], book_side[64], price[82:65], quantity[113:83], zero fill
  input  wire logic [119:0] in_tdata,
  // mode[0]
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // bid_px[17:0], ask_px[35:18], zero fill
  output logic [39:0]       out_tdata,
  // status[1:0]
  output logic [plob_pkg::STATUS_W-1:0] out_tuser
);
  import plob_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_HASH, S_PRB_RD, S_PRB_CHK, S_LVL_RD, S_LVL_UPD,
    S_LEAF_RD, S_LEAF_UPD, S_MID_UPD, S_REM_START, S_REM_RD, S_REM_CHK,
    S_REM_HASH, S_REM_MOVE, S_BEST_TOP, S_BEST_MID_RD, S_BEST_MID,
    S_BEST_LEAF_RD, S_BEST_LEAF, S_OUT
  } state_t;

  // Memories.
  logic [ID_W-1:0]  ids_mem  [TABLE_SLOTS];
  slot_info_t       info_mem [TABLE_SLOTS];
  logic [LVL_W-1:0] lvl_mem  [2 ** LVL_AW];
  logic [63:0]      leaf_mem [2 ** LEAF_AW];
  logic [63:0]      mid_mem  [2 ** MID_AW];

  logic [ID_W-1:0]  ids_q;
  slot_info_t       info_q;
  logic [LVL_W-1:0] lvl_q;
  logic [63:0]      leaf_q;
  logic [63:0]      mid_q;

  // Control and item registers.
  state_t              state_r;
  logic [CLR_W-1:0]    clr_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [63:0]         top_r [2];
  logic                mode_r;
  logic [ID_W-1:0]     key_r;
  logic                side_r;
  logic [PRICE_W-1:0]  price_r;
  logic [QTY_W-1:0]    qty_r;
  logic [SLOT_AW-1:0]  idx_r;
  logic [SLOT_AW-1:0]  hole_r;
  logic                unmark_r;
  logic                bs_r;
  logic [LEAF_AW-1:0]  leaf_addr_r;
  logic [MID_AW-1:0]   mid_addr_r;
  logic [PRICE_W-1:0]  bid_r;
  logic [PRICE_W-1:0]  ask_r;
  logic [STATUS_W-1:0] status_r;
  logic                out_valid_r;
  logic [PRICE_W-1:0]  out_bid_r;
  logic [PRICE_W-1:0]  out_ask_r;
  logic [STATUS_W-1:0] out_status_r;

  // Input fields.
  logic [ID_W-1:0]    in_order_id;
  logic               in_book_side;
  logic [PRICE_W-1:0] in_price;
  logic [QTY_W-1:0]   in_quantity;
  logic               in_acc;
  logic               reject;

  // Hash unit connection.
  logic               hash_start;
  logic [63:0]        hash_key;
  logic               hash_busy;
  logic               hash_done;
  logic [SLOT_AW-1:0] hash_home;

  // Datapath values.
  logic             probe_hit;
  logic [LVL_W:0]   lvl_sum;
  logic [LVL_W-1:0] lvl_new;
  logic             lvl_drop;
  logic [63:0]      leaf_bit;
  logic [63:0]      mid_bit;
  logic [63:0]      top_bit;
  logic [63:0]      leaf_new;
  logic [63:0]      mid_new;
  logic [63:0]      top_sel;
  logic [5:0]       enc_top;
  logic [5:0]       enc_mid;
  logic [5:0]       enc_leaf;
  logic             after_cancel;

  // Write ports.
  logic               ids_we;
  logic [SLOT_AW-1:0] ids_waddr;
  logic [ID_W-1:0]    ids_wdata;
  logic               info_we;
  logic [SLOT_AW-1:0] info_waddr;
  slot_info_t         info_wdata;
  logic               lvl_we;
  logic [LVL_AW-1:0]  lvl_waddr;
  logic [LVL_W-1:0]   lvl_wdata;
  logic               leaf_we;
  logic [LEAF_AW-1:0] leaf_waddr;
  logic [63:0]        leaf_wdata;
  logic               mid_we;
  logic [MID_AW-1:0]  mid_waddr;
  logic [63:0]        mid_wdata;

  assign in_order_id  = in_tdata[63:0];
  assign in_book_side = in_tdata[64];
  assign in_price     = in_tdata[82:65];
  assign in_quantity  = in_tdata[113:83];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign reject    = (in_tuser == MODE_ADD) && (cnt_r >= CNT_W'(HALF_LOAD));

  // Hash requests come from a new item or from a walked slot during deletion.
  assign hash_start = (in_acc && !reject) || ((state_r == S_REM_CHK) && info_q.used);
  assign hash_key   = (state_r == S_IDLE) ? in_order_id : ids_q;

  plob_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (hash_key),
    .busy  (hash_busy),
    .done  (hash_done),
    .home  (hash_home)
  );

  // Level arithmetic and bitmap masks.
  always_comb begin
    probe_hit = !info_q.used || (ids_q == key_r);
    lvl_sum   = {1'b0, lvl_q} + (LVL_W + 1)'(qty_r);
    lvl_drop  = (lvl_q <= LVL_W'(qty_r));
    if (mode_r == MODE_ADD) begin
      lvl_new = lvl_sum[LVL_W] ? {LVL_W{1'b1}} : lvl_sum[LVL_W-1:0];
    end else begin
      lvl_new = lvl_drop ? '0 : (lvl_q - LVL_W'(qty_r));
    end
    leaf_bit     = 64'd1 << price_r[5:0];
    mid_bit      = 64'd1 << price_r[11:6];
    top_bit      = 64'd1 << price_r[PRICE_W-1:12];
    leaf_new     = unmark_r ? (leaf_q & ~leaf_bit) : (leaf_q | leaf_bit);
    mid_new      = unmark_r ? (mid_q & ~mid_bit) : (mid_q | mid_bit);
    top_sel      = top_r[bs_r];
    enc_top      = bs_r ? lo_bit(top_sel) : hi_bit(top_sel);
    enc_mid      = bs_r ? lo_bit(mid_q) : hi_bit(mid_q);
    enc_leaf     = bs_r ? lo_bit(leaf_q) : hi_bit(leaf_q);
    after_cancel = (mode_r == MODE_CANCEL);
  end

  // Memory write selection by sequencer state.
  always_comb begin
    ids_we     = 1'b0;
    ids_waddr  = idx_r;
    ids_wdata  = key_r;
    info_we    = 1'b0;
    info_waddr = idx_r;
    info_wdata = '0;
    lvl_we     = 1'b0;
    lvl_waddr  = {side_r, price_r};
    lvl_wdata  = lvl_new;
    leaf_we    = 1'b0;
    leaf_waddr = leaf_addr_r;
    leaf_wdata = leaf_new;
    mid_we     = 1'b0;
    mid_waddr  = mid_addr_r;
    mid_wdata  = mid_new;
    unique case (state_r)
      S_CLEAR: begin
        info_we    = 1'b1;
        info_waddr = clr_r[SLOT_AW-1:0];
        lvl_we     = 1'b1;
        lvl_waddr  = clr_r[LVL_AW-1:0];
        lvl_wdata  = '0;
        leaf_we    = 1'b1;
        leaf_waddr = clr_r[LEAF_AW-1:0];
        leaf_wdata = '0;
        mid_we     = 1'b1;
        mid_waddr  = clr_r[MID_AW-1:0];
        mid_wdata  = '0;
      end
      S_PRB_CHK: begin
        if (probe_hit && (mode_r == MODE_ADD)) begin
          ids_we     = 1'b1;
          info_we    = 1'b1;
          info_wdata = '{used: 1'b1, side: side_r, price: price_r, qty: qty_r};
        end
      end
      S_LVL_UPD:  lvl_we  = 1'b1;
      S_LEAF_UPD: leaf_we = 1'b1;
      S_MID_UPD:  mid_we  = 1'b1;
      S_REM_START: begin
        info_we    = 1'b1;
        info_waddr = hole_r;
      end
      S_REM_MOVE: begin
        ids_we     = 1'b1;
        ids_waddr  = hole_r;
        ids_wdata  = ids_q;
        info_we    = 1'b1;
        info_waddr = hole_r;
        info_wdata = info_q;
      end
      default: ;
    endcase
  end

  // Slot memories.
  always_ff @(posedge clk) begin
    if (ids_we) begin
      ids_mem[ids_waddr] <= ids_wdata;
    end
    ids_q <= ids_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (info_we) begin
      info_mem[info_waddr] <= info_wdata;
    end
    info_q <= info_mem[idx_r];
  end

  // Level sum memory.
  always_ff @(posedge clk) begin
    if (lvl_we) begin
      lvl_mem[lvl_waddr] <= lvl_wdata;
    end
    lvl_q <= lvl_mem[{side_r, price_r}];
  end

  // Leaf and middle bitmap memories.
  always_ff @(posedge clk) begin
    if (leaf_we) begin
      leaf_mem[leaf_waddr] <= leaf_wdata;
    end
    leaf_q <= leaf_mem[leaf_addr_r];
  end

  always_ff @(posedge clk) begin
    if (mid_we) begin
      mid_mem[mid_waddr] <= mid_wdata;
    end
    mid_q <= mid_mem[mid_addr_r];
  end

  // Sequencer and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      top_r[0]    <= '0;
      top_r[1]    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The result register fills in hand-off and empties when its item is taken.
      out_valid_r <= (state_r == S_OUT) || (out_valid_r && !out_tready);
      unique case (state_r)
        S_CLEAR: begin
          if (clr_r == CLR_W'(CLR_N - 1)) begin
            state_r <= S_IDLE;
          end else begin
            clr_r <= clr_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            mode_r   <= in_tuser;
            key_r    <= in_order_id;
            side_r   <= in_book_side;
            price_r  <= sat_price(in_price);
            qty_r    <= in_quantity;
            bs_r     <= SIDE_BID;
            status_r <= reject ? ST_REJECT : ST_DONE;
            state_r  <= reject ? S_BEST_TOP : S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            idx_r   <= hash_home;
            state_r <= S_PRB_RD;
          end
        end
        S_PRB_RD: state_r <= S_PRB_CHK;
        S_PRB_CHK: begin
          if (!probe_hit) begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_PRB_RD;
          end else if (mode_r == MODE_ADD) begin
            if (!info_q.used) begin
              cnt_r <= cnt_r + 1'b1;
            end
            state_r <= S_LVL_RD;
          end else if (!info_q.used) begin
            status_r <= ST_NOT_FOUND;
            state_r  <= S_BEST_TOP;
          end else begin
            side_r  <= info_q.side;
            price_r <= sat_price(info_q.price);
            qty_r   <= info_q.qty;
            hole_r  <= idx_r;
            if (cnt_r != '0) begin
              cnt_r <= cnt_r - 1'b1;
            end
            state_r <= S_LVL_RD;
          end
        end
        S_LVL_RD: state_r <= S_LVL_UPD;
        S_LVL_UPD: begin
          leaf_addr_r <= {side_r, price_r[PRICE_W-1:6]};
          mid_addr_r  <= {side_r, price_r[PRICE_W-1:12]};
          unmark_r    <= after_cancel;
          if (after_cancel ? lvl_drop : (lvl_q == '0)) begin
            state_r <= S_LEAF_RD;
          end else begin
            state_r <= after_cancel ? S_REM_START : S_BEST_TOP;
          end
        end
        S_LEAF_RD: state_r <= S_LEAF_UPD;
        S_LEAF_UPD: begin
          if (unmark_r && (leaf_new != '0)) begin
            state_r <= after_cancel ? S_REM_START : S_BEST_TOP;
          end else begin
            state_r <= S_MID_UPD;
          end
        end
        S_MID_UPD: begin
          if (!unmark_r) begin
            top_r[side_r] <= top_r[side_r] | top_bit;
          end else if (mid_new == '0) begin
            top_r[side_r] <= top_r[side_r] & ~top_bit;
          end
          state_r <= after_cancel ? S_REM_START : S_BEST_TOP;
        end
        // Backward-shift deletion: free the hole, then walk its chain.
        S_REM_START: begin
          idx_r   <= hole_r + 1'b1;
          state_r <= S_REM_RD;
        end
        S_REM_RD: state_r <= S_REM_CHK;
        S_REM_CHK: begin
          state_r <= info_q.used ? S_REM_HASH : S_BEST_TOP;
        end
        S_REM_HASH: begin
          if (hash_done) begin
            if (ring_between(hole_r, hash_home, idx_r)) begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_REM_RD;
            end else begin
              state_r <= S_REM_MOVE;
            end
          end
        end
        S_REM_MOVE: begin
          hole_r  <= idx_r;
          state_r <= S_REM_START;
        end
        // Best price search, bid side first then ask side.
        S_BEST_TOP: begin
          if (top_sel == '0) begin
            if (bs_r == SIDE_BID) begin
              bid_r <= '0;
              bs_r  <= SIDE_ASK;
            end else begin
              ask_r   <= '0;
              state_r <= S_OUT;
            end
          end else begin
            mid_addr_r <= {bs_r, enc_top};
            state_r    <= S_BEST_MID_RD;
          end
        end
        S_BEST_MID_RD: state_r <= S_BEST_MID;
        S_BEST_MID: begin
          leaf_addr_r <= {bs_r, mid_addr_r[MID_IW-1:0], enc_mid};
          state_r     <= S_BEST_LEAF_RD;
        end
        S_BEST_LEAF_RD: state_r <= S_BEST_LEAF;
        S_BEST_LEAF: begin
          if (bs_r == SIDE_BID) begin
            bid_r   <= {leaf_addr_r[LEAF_IW-1:0], enc_leaf};
            bs_r    <= SIDE_ASK;
            state_r <= S_BEST_TOP;
          end else begin
            ask_r   <= {leaf_addr_r[LEAF_IW-1:0], enc_leaf};
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_bid_r    <= bid_r;
            out_ask_r    <= ask_r;
            out_status_r <= status_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_ask_r, out_bid_r};
  assign out_tuser  = out_status_r;

  // The order count never passes half the table.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(HALF_LOAD))
    else $error("order count above half load");

  // A new result appears only from the output hand-off state.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside hand-off");

  // The hash unit is never restarted while it works.
  a_hash_free: assert property (@(posedge clk) disable iff (!rst_n)
    hash_start |-> !hash_busy)
    else $error("hash started while busy");

  // A rejected add leaves the order count alone.
  a_reject_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && reject) |=> $stable(cnt_r))
    else $error("rejected add changed order count");

endmodule

`default_nettype wire

>>> hdl/plob_hash.sv
// ----------------------------------------------------------------------------
// Order id hash unit
// Mixing finalizer of a 64-bit id folded to a table slot. Each 64-bit product
// is built from three 32x32 partial products on one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module plob_hash (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [63:0]                  key,
  output logic                              busy,
  output logic                              done,
  output logic [plob_pkg::SLOT_AW-1:0]      home
);
  import plob_pkg::*;

  typedef enum logic {H_IDLE, H_RUN} hstate_t;

  hstate_t            state_r;
  logic [1:0]         step_r;
  logic               round_r;
  logic               done_r;
  logic [63:0]        x_r;
  logic [63:0]        acc_r;
  logic [63:0]        prod_r;
  logic [SLOT_AW-1:0] home_r;

  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] mul_c;
  logic [63:0] prod_nxt;
  logic [63:0] acc_nxt;
  logic [63:0] mixed;

  // Operand selection: low*low, high*low, low*high; the high*high term drops out.
  always_comb begin
    mul_c    = round_r ? MIX_C2 : MIX_C1;
    op_a     = (step_r == 2'd1) ? x_r[63:32] : x_r[31:0];
    op_b     = (step_r == 2'd2) ? mul_c[63:32] : mul_c[31:0];
    prod_nxt = op_a * op_b;
    case (step_r)
      2'd0:    acc_nxt = acc_r;
      2'd1:    acc_nxt = prod_r;
      default: acc_nxt = {acc_r[63:32] + prod_r[31:0], acc_r[31:0]};
    endcase
    mixed = round_r ? (acc_nxt ^ (acc_nxt >> 31)) : (acc_nxt ^ (acc_nxt >> 27));
  end

  // Sequencer: four steps per multiply, two multiplies per id.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        H_IDLE: begin
          if (start) begin
            x_r     <= key ^ (key >> 30);
            step_r  <= 2'd0;
            round_r <= 1'b0;
            state_r <= H_RUN;
          end
        end
        H_RUN: begin
          prod_r <= prod_nxt;
          acc_r  <= acc_nxt;
          step_r <= step_r + 2'd1;
          if (step_r == 2'd3) begin
            if (!round_r) begin
              x_r     <= mixed;
              round_r <= 1'b1;
            end else begin
              home_r  <= mixed[SLOT_AW-1:0];
              done_r  <= 1'b1;
              state_r <= H_IDLE;
            end
          end
        end
        default: state_r <= H_IDLE;
      endcase
    end
  end

  assign busy = (state_r == H_RUN);
  assign done = done_r;
  assign home = home_r;

endmodule

`default_nettype wire

>>> bench/plob_book_checker.sv
// ----------------------------------------------------------------------------
// Order book result checker
// Watches the item and result channels of the order book. Each accepted item
// runs through a behavioral book model: order table with linear probing and
// backward-shift deletion, per-side level sums and occupancy sets. The
// expected best bid, best ask and status are queued and compared in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module plob_book_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [119:0] in_tdata,
  input  wire logic         in_tuser,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [39:0]  out_tdata,
  input  wire logic [plob_pkg::STATUS_W-1:0] out_tuser,
  output int                fail_count,
  output int                quotes_pending,
  output int                quotes_seen,
  output int                misses_seen
);
  import plob_pkg::*;

  localparam logic [LVL_W-1:0] LEVEL_FULL = '1;

  typedef struct packed {
    logic [PRICE_W-1:0]  bid;
    logic [PRICE_W-1:0]  ask;
    logic [STATUS_W-1:0] status;
  } quote_t;

  // Model state of the book.
  bit                 slot_used  [TABLE_SLOTS];
  bit [ID_W-1:0]      slot_id    [TABLE_SLOTS];
  bit                 slot_side  [TABLE_SLOTS];
  bit [PRICE_W-1:0]   slot_price [TABLE_SLOTS];
  bit [QTY_W-1:0]     slot_qty   [TABLE_SLOTS];
  bit [LVL_W-1:0]     level_sum  [2][NUM_PRICES];
  bit                 bid_levels [int];
  bit                 ask_levels [int];
  int                 live_orders;
  quote_t             quote_queue[$];

  // Home slot of an id: splitmix64 finalizer folded to the table size.
  function automatic logic [SLOT_AW-1:0] home_slot(input logic [ID_W-1:0] id);
    logic [63:0] x;
    x = id;
    x = x ^ (x >> 30);
    x = x * MIX_C1;
    x = x ^ (x >> 27);
    x = x * MIX_C2;
    x = x ^ (x >> 31);
    return x[SLOT_AW-1:0];
  endfunction

  // Slot holding the id, or the first free slot of its probe chain.
  function automatic int locate_slot(input logic [ID_W-1:0] id);
    int k;
    k = home_slot(id);
    for (int n = 0; n < TABLE_SLOTS; n++) begin
      if (!slot_used[k] || slot_id[k] == id) return k;
      k = (k + 1) % TABLE_SLOTS;
    end
    return k;
  endfunction

  // Backward-shift deletion starting at the freed slot.
  function automatic void unlink_slot(input int pos);
    int  i, j, h;
    bit  movable;
    i = pos;
    for (int n = 0; n < TABLE_SLOTS; n++) begin
      slot_used[i] = 1'b0;
      j = i;
      movable = 1'b0;
      for (int m = 0; m < TABLE_SLOTS; m++) begin
        j = (j + 1) % TABLE_SLOTS;
        if (!slot_used[j]) return;
        h = home_slot(slot_id[j]);
        // An entry may move back unless its home lies in the ring span (i, j].
        if (i <= j ? !(i < h && h <= j) : !(i < h || h <= j)) begin
          movable = 1'b1;
          break;
        end
      end
      if (!movable) return;
      slot_used[i]  = 1'b1;
      slot_id[i]    = slot_id[j];
      slot_side[i]  = slot_side[j];
      slot_price[i] = slot_price[j];
      slot_qty[i]   = slot_qty[j];
      i = j;
    end
  endfunction

  // Apply one add or cancel and return the book's quote afterwards.
  function automatic quote_t apply_order(input logic mode, input logic [ID_W-1:0] id,
                                         input logic side, input logic [PRICE_W-1:0] price,
                                         input logic [QTY_W-1:0] qty);
    quote_t       q;
    int           k, key;
    logic [LVL_W:0] sum;
    q.status = ST_DONE;
    if (mode == MODE_ADD) begin
      if (2 * (live_orders + 1) > TABLE_SLOTS) begin
        q.status = ST_REJECT;
      end else begin
        k = locate_slot(id);
        if (!slot_used[k]) live_orders++;
        slot_used[k]  = 1'b1;
        slot_id[k]    = id;
        slot_side[k]  = side;
        slot_price[k] = price;
        slot_qty[k]   = qty;
        if (level_sum[side][price] == 0) begin
          if (side == SIDE_BID) bid_levels[price] = 1'b1;
          else ask_levels[price] = 1'b1;
        end
        sum = {1'b0, level_sum[side][price]} + qty;
        level_sum[side][price] = (sum > LEVEL_FULL) ? LEVEL_FULL : sum[LVL_W-1:0];
      end
    end else begin
      k = locate_slot(id);
      if (!slot_used[k] || slot_id[k] != id) begin
        q.status = ST_NOT_FOUND;
      end else begin
        if (level_sum[slot_side[k]][slot_price[k]] <= slot_qty[k]) begin
          level_sum[slot_side[k]][slot_price[k]] = '0;
          if (slot_side[k] == SIDE_BID) bid_levels.delete(slot_price[k]);
          else ask_levels.delete(slot_price[k]);
        end else begin
          level_sum[slot_side[k]][slot_price[k]] -= slot_qty[k];
        end
        unlink_slot(k);
        if (live_orders > 0) live_orders--;
      end
    end
    q.bid = bid_levels.last(key) ? key[PRICE_W-1:0] : '0;
    q.ask = ask_levels.first(key) ? key[PRICE_W-1:0] : '0;
    return q;
  endfunction

  // Predict on accepted items, compare on accepted results.
  always @(posedge clk) begin
    quote_t want, got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        quote_queue.push_back(apply_order(in_tuser, in_tdata[63:0], in_tdata[64],
                                          in_tdata[82:65], in_tdata[113:83]));
      end
      if (out_tvalid && out_tready) begin
        got.bid    = out_tdata[17:0];
        got.ask    = out_tdata[35:18];
        got.status = out_tuser;
        quotes_seen++;
        if (got.status == ST_NOT_FOUND) misses_seen++;
        if (quote_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: result with no item waiting: bid %0d ask %0d st %0d",
                     got.bid, got.ask, got.status);
        end else begin
          want = quote_queue.pop_front();
          if (got != want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("ERROR: result %0d: bid %0d/%0d ask %0d/%0d status %0d/%0d (exp/act)",
                       quotes_seen, want.bid, got.bid, want.ask, got.ask,
                       want.status, got.status);
          end
        end
      end
      quotes_pending = quote_queue.size();
    end
  end

  initial begin
    fail_count     = 0;
    quotes_pending = 0;
    quotes_seen    = 0;
    misses_seen    = 0;
    live_orders    = 0;
  end

endmodule

`default_nettype wire

>>> bench/tb_price_level_order_book.sv
// ----------------------------------------------------------------------------
// Order book testbench
// Drives adds and cancels into the order book in random bursts while the
// result side stalls on its own pattern, including one long hold-off. A
// directed opening covers price extremes, zero quantity, duplicate adds and
// unknown cancels; random traffic then works a pool of ids that share one
// small, wrapping region of the table to stress probing and deletion.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_price_level_order_book;
  import plob_pkg::*;

  localparam int RANDOM_ITEMS = 830;
  localparam int CLUSTER_IDS  = 24;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [119:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [39:0]  out_tdata;
  logic [STATUS_W-1:0] out_tuser;

  int fail_count, quotes_pending, quotes_seen, misses_seen;
  int items_sent;
  int burst_left;
  bit long_hold_done;

  logic [ID_W-1:0] cluster_pool[$];
  logic [ID_W-1:0] resting_ids[$];

  price_level_order_book i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  plob_book_checker i_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .fail_count     (fail_count),
    .quotes_pending (quotes_pending),
    .quotes_seen    (quotes_seen),
    .misses_seen    (misses_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one item and hold it until taken; gaps fall between bursts.
  task automatic send_order(input logic mode, input logic [ID_W-1:0] id,
                            input logic side, input logic [PRICE_W-1:0] price,
                            input logic [QTY_W-1:0] qty);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {6'd0, qty, price, side, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic enter_order(input logic [ID_W-1:0] id, input logic side,
                             input logic [PRICE_W-1:0] price, input logic [QTY_W-1:0] qty);
    send_order(MODE_ADD, id, side, price, qty);
    resting_ids.push_back(id);
  endtask

  // A cancel carries random content in the fields it ignores.
  task automatic withdraw_order(input logic [ID_W-1:0] id);
    send_order(MODE_CANCEL, id, 1'($urandom), 18'($urandom), 31'($urandom));
  endtask

  // Prices mostly near a few word boundaries and the extremes.
  function automatic logic [PRICE_W-1:0] pick_price();
    case ($urandom_range(0, 4))
      0: return 18'($urandom_range(0, 70));
      1: return 18'(NUM_PRICES - 1 - $urandom_range(0, 70));
      2: return 18'(4096 * $urandom_range(1, 60) + $urandom_range(0, 130) - 65);
      default: return 18'($urandom);
    endcase
  endfunction

  function automatic logic [QTY_W-1:0] pick_qty();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return 31'($urandom_range(1, 1000));
    endcase
  endfunction

  function automatic logic [ID_W-1:0] pick_new_id();
    if (cluster_pool.size() > 0 && $urandom_range(0, 2) != 0)
      return cluster_pool[$urandom_range(0, cluster_pool.size() - 1)];
    return {$urandom, $urandom};
  endfunction

  // Result side: changing stall patterns, and one long hold once traffic runs.
  initial begin
    int style;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!long_hold_done && items_sent >= 300) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold_done = 1'b1;
      end
      style = $urandom_range(0, 3);
      repeat ($urandom_range(20, 100)) begin
        case (style)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= 1'($urandom);
        endcase
        @(posedge clk);
      end
    end
  end

  // Run limit.
  initial begin
    #(64'd60_000_000);
    $display("TEST FAILED");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    logic [ID_W-1:0] id;
    int idx, waited;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= MODE_ADD;
    rst_n     <= 1'b0;
    items_sent = 0;
    burst_left = 0;
    long_hold_done = 1'b0;

    // Ids whose home slots sit in one region that wraps past the table end.
    while (cluster_pool.size() < CLUSTER_IDS) begin
      id = {$urandom, $urandom};
      idx = i_chk.home_slot(id);
      if (idx >= TABLE_SLOTS - 24 || idx < 8) cluster_pool.push_back(id);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: extremes, zero quantity, duplicates, unknown ids.
    withdraw_order(64'h1234);
    enter_order('0, SIDE_BID, 18'(NUM_PRICES - 1), '1);
    enter_order('1, SIDE_ASK, '0, '1);
    enter_order(64'h55, SIDE_ASK, 18'(NUM_PRICES - 1), 31'd7);
    enter_order(64'h56, SIDE_BID, '0, '0);
    enter_order(64'h57, SIDE_BID, 18'd4095, '0);
    enter_order(64'h55, SIDE_BID, 18'd4096, 31'd9);
    enter_order(cluster_pool[0], SIDE_ASK, 18'd100, 31'd3);
    enter_order(cluster_pool[1], SIDE_ASK, 18'd100, 31'd4);
    enter_order(cluster_pool[2], SIDE_BID, 18'd63, 31'd5);
    enter_order(cluster_pool[3], SIDE_BID, 18'd64, 31'd6);
    withdraw_order('1);
    withdraw_order('0);
    withdraw_order(cluster_pool[0]);
    withdraw_order(cluster_pool[0]);
    withdraw_order(64'h57);
    withdraw_order(64'h56);
    withdraw_order(cluster_pool[3]);
    withdraw_order(64'h55);
    withdraw_order(cluster_pool[1]);
    withdraw_order(cluster_pool[2]);
    resting_ids.delete();

    // Random traffic: mostly adds and cancels of resting orders.
    repeat (RANDOM_ITEMS) begin
      case ($urandom_range(0, 9)) inside
        [0:3]: begin
          enter_order(pick_new_id(), 1'($urandom), pick_price(), pick_qty());
        end
        4: begin
          if (resting_ids.size() > 0)
            enter_order(resting_ids[$urandom_range(0, resting_ids.size() - 1)],
                        1'($urandom), pick_price(), pick_qty());
          else
            withdraw_order({$urandom, $urandom});
        end
        5: withdraw_order($urandom_range(0, 1) ? {$urandom, $urandom} : pick_new_id());
        default: begin
          if (resting_ids.size() > 0) begin
            idx = $urandom_range(0, resting_ids.size() - 1);
            withdraw_order(resting_ids[idx]);
            resting_ids.delete(idx);
          end else begin
            enter_order(pick_new_id(), 1'($urandom), pick_price(), pick_qty());
          end
        end
      endcase
      // Keep the book shallow so the cluster drains and refills.
      if (resting_ids.size() > 60) begin
        while (resting_ids.size() > 10) begin
          withdraw_order(resting_ids.pop_front());
        end
      end
    end
    in_tvalid <= 1'b0;

    waited = 0;
    while (quotes_pending != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);

    $display("Sent %0d adds and cancels, %0d results checked, %0d of them unknown cancels.",
             items_sent, quotes_seen, misses_seen);
    $display("Random traffic worked %0d ids homed in one wrapping table region.",
             CLUSTER_IDS);
    if (fail_count == 0 && quotes_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
hdl/plob_pkg.sv
hdl/plob_hash.sv
hdl/price_level_order_book.sv
bench/plob_book_checker.sv
bench/tb_price_level_order_book.sv
